// ===== rtl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, register indexes and types of the nearest-neighbor selector.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int IDX_W       = 16;
    localparam int DIM         = 3;
    localparam int DIMS_W      = 2;
    localparam int WANT_W      = 5;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 8;

    localparam int K_MAX_DEF      = 16;
    localparam int MAX_POINTS_DEF = 65536;

    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_QUERY_2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DIMS    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WANTED  = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] q0;
        logic signed [COORD_W-1:0] q1;
        logic signed [COORD_W-1:0] q2;
        logic [DIMS_W-1:0]         dims;
    } knn_query_t;

    // one classified point on its way to the sorted list
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
        logic              ins;
        logic              last;
        logic              ovf;
    } knn_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             ovf;
    } knn_result_t;

endpackage

// ===== rtl/k_nearest_neighbor_select.sv =====
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select
// Streams training points and reports the nearest ones to a query point.
// ----------------------------------------------------------------------------
// Points are taken at one per cycle and pass the distance pipeline into an
// eight-word queue; the list of K_MAX compare cells takes one point from the
// queue per cycle while not emitting, so insertion sets the sustained rate. A
// word with s_tlast ends the run: the list then shifts out min(m, points kept)
// indices, one per cycle while m_tready is high; input keeps flowing meanwhile
// and stalls once queue and pipeline hold eight points. Configuration must
// be written only while the block is idle; the block does not enforce it.
module k_nearest_neighbor_select #(
    parameter int K_MAX      = knn_pkg::K_MAX_DEF,
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,   // coord_0, coord_1, coord_2
    input  logic                               s_tlast,   // last_point
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // neighbor_index
    output logic                               m_tlast,   // last_neighbor
    output logic [0:0]                         m_tuser,   // points_dropped
    input  logic                               cfg_wr_en,
    input  logic [knn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [knn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import knn_pkg::*;

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    knn_query_t        query_reg;
    logic [WANT_W-1:0] wanted_reg;
    logic              push, pop, head_valid;
    knn_item_t         push_item, head_item;
    logic [QC_W-1:0]   queue_count;
    knn_result_t       result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg.q0   <= '0;
            query_reg.q1   <= '0;
            query_reg.q2   <= '0;
            query_reg.dims <= DIMS_W'(2);
            wanted_reg     <= WANT_W'(16);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_QUERY_0: query_reg.q0   <= cfg_wdata;
                REG_QUERY_1: query_reg.q1   <= cfg_wdata;
                REG_QUERY_2: query_reg.q2   <= cfg_wdata;
                REG_DIMS:    query_reg.dims <= cfg_wdata[DIMS_W-1:0];
                REG_WANTED:  wanted_reg     <= cfg_wdata[WANT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    knn_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .query      (query_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .coord_0    (s_tdata[23:0]),
        .coord_1    (s_tdata[47:24]),
        .coord_2    (s_tdata[71:48]),
        .last_point (s_tlast),
        .queue_count(queue_count),
        .push       (push),
        .push_item  (push_item)
    );

    knn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_valid(head_valid),
        .head_item (head_item),
        .count     (queue_count)
    );

    knn_back #(
        .K_MAX(K_MAX)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .neighbors_wanted(wanted_reg),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_result      (result)
    );

    assign m_tdata    = result.idx;
    assign m_tlast    = result.last;
    assign m_tuser[0] = result.ovf;

endmodule

// ===== rtl/knn_front.sv =====
// ----------------------------------------------------------------------------
// knn_front
// Accepts points, numbers them, flags overflow and forms squared distances.
// ----------------------------------------------------------------------------
module knn_front #(
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  knn_pkg::knn_query_t                 query,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [knn_pkg::COORD_W-1:0]  coord_0,
    input  logic signed [knn_pkg::COORD_W-1:0]  coord_1,
    input  logic signed [knn_pkg::COORD_W-1:0]  coord_2,
    input  logic                                last_point,
    input  logic [$clog2(knn_pkg::QUEUE_DEPTH+1)-1:0] queue_count,
    output logic                                push,
    output knn_pkg::knn_item_t                  push_item
);
    import knn_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             accept;
    logic             drop;
    logic [1:0]       dims_eff;
    logic [CNT_W+IDX_W-1:0] idx_wide;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0] d0_reg, d1_reg, d2_reg;
    logic signed [DIFF_W-1:0] d0_next, d1_next, d2_next;
    logic [SQ_W-1:0]          s0_reg, s1_reg, s2_reg;
    logic signed [2*DIFF_W-1:0] p0, p1, p2;
    logic [DIST_W-1:0]        dist_reg;
    logic [IDX_W-1:0]         idx1_reg, idx2_reg, idx3_reg;
    logic [2:0]               fl1_reg, fl2_reg, fl3_reg;  // ins, last, ovf
    logic [QC_W-1:0]          in_flight;

    // every point in the pipe already owns a queue slot
    assign in_flight = queue_count + QC_W'(v1_reg) + QC_W'(v2_reg) + QC_W'(v3_reg);
    assign in_ready  = (in_flight < QC_W'(QUEUE_DEPTH));
    assign accept    = in_valid && in_ready;
    assign drop      = (count_reg == CNT_W'(MAX_POINTS));
    assign idx_wide  = {{IDX_W{1'b0}}, count_reg};

    always_comb begin
        if (query.dims == 2'd0) begin
            dims_eff = 2'd1;
        end else if (query.dims > 2'(DIM)) begin
            dims_eff = 2'(DIM);
        end else begin
            dims_eff = query.dims;
        end
    end

    always_comb begin
        d0_next = DIFF_W'(coord_0) - DIFF_W'(query.q0);
        d1_next = (dims_eff > 2'd1) ? DIFF_W'(coord_1) - DIFF_W'(query.q1) : '0;
        d2_next = (dims_eff > 2'd2) ? DIFF_W'(coord_2) - DIFF_W'(query.q2) : '0;
    end

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (last_point) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                if (!drop) begin
                    count_next = count_reg + 1'b1;
                end
                ovf_next = ovf_reg || drop;
            end
        end
    end

    assign p0 = d0_reg * d0_reg;
    assign p1 = d1_reg * d1_reg;
    assign p2 = d2_reg * d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        idx1_reg <= idx_wide[IDX_W-1:0];
        fl1_reg  <= {!drop, last_point, ovf_reg || drop};
        s0_reg   <= p0[SQ_W-1:0];
        s1_reg   <= p1[SQ_W-1:0];
        s2_reg   <= p2[SQ_W-1:0];
        idx2_reg <= idx1_reg;
        fl2_reg  <= fl1_reg;
        dist_reg <= DIST_W'(s0_reg) + DIST_W'(s1_reg) + DIST_W'(s2_reg);
        idx3_reg <= idx2_reg;
        fl3_reg  <= fl2_reg;
    end

    assign push              = v3_reg;
    assign push_item.sq_dist = dist_reg;
    assign push_item.idx     = idx3_reg;
    assign push_item.ins     = fl3_reg[2];
    assign push_item.last    = fl3_reg[1];
    assign push_item.ovf     = fl3_reg[0];

endmodule

// ===== rtl/knn_queue.sv =====
// ----------------------------------------------------------------------------
// knn_queue
// Short first-in first-out queue between the front and the sorted list.
// ----------------------------------------------------------------------------
module knn_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  knn_pkg::knn_item_t  push_item,
    input  logic                pop,
    output logic                head_valid,
    output knn_pkg::knn_item_t  head_item,
    output logic [$clog2(knn_pkg::QUEUE_DEPTH+1)-1:0] count
);
    import knn_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    knn_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;

    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PTR_W'((int'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (pop) begin
                rd_ptr_reg <= PTR_W'((int'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            count_reg <= count_reg + QC_W'(push) - QC_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/knn_back.sv =====
// ----------------------------------------------------------------------------
// knn_back
// Sorted list of compare cells; inserts one point a cycle unless shifting out results.
// ----------------------------------------------------------------------------
module knn_back #(
    parameter int K_MAX = knn_pkg::K_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [knn_pkg::WANT_W-1:0]    neighbors_wanted,
    input  logic                          head_valid,
    input  knn_pkg::knn_item_t            head_item,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output knn_pkg::knn_result_t          out_result
);
    import knn_pkg::*;

    localparam int FILL_W = $clog2(K_MAX + 1);
    localparam logic ST_INSERT = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic              state_reg, state_next;
    logic [FILL_W-1:0] filled_reg, filled_next;
    logic [FILL_W-1:0] remain_reg, remain_next;
    logic              run_ovf_reg, run_ovf_next;
    logic [DIST_W-1:0] dist_reg [K_MAX];
    logic [DIST_W-1:0] dist_next [K_MAX];
    logic [IDX_W-1:0]  pt_reg [K_MAX];
    logic [IDX_W-1:0]  pt_next [K_MAX];
    logic [K_MAX-1:0]  le;
    logic              out_valid_reg, out_valid_next;
    knn_result_t       out_reg, out_next;
    logic              out_free;

    assign pop        = (state_reg == ST_INSERT) && head_valid;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // each cell holding an entry no worse than the new point keeps its place
    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            le[j] = (FILL_W'(j) < filled_reg) && (dist_reg[j] <= head_item.sq_dist);
        end
    end

    always_comb begin
        int unsigned n_take;
        state_next     = state_reg;
        filled_next    = filled_reg;
        remain_next    = remain_reg;
        run_ovf_next   = run_ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        n_take         = 0;
        for (int j = 0; j < K_MAX; j++) begin
            dist_next[j] = dist_reg[j];
            pt_next[j]   = pt_reg[j];
        end
        unique case (state_reg)
            ST_INSERT: begin
                if (pop) begin
                    if (head_item.ins && !le[K_MAX-1]) begin
                        for (int j = 0; j < K_MAX; j++) begin
                            if (!le[j]) begin
                                if (j == 0 || le[(j > 0) ? j - 1 : 0]) begin
                                    dist_next[j] = head_item.sq_dist;
                                    pt_next[j]   = head_item.idx;
                                end else begin
                                    dist_next[j] = dist_reg[(j > 0) ? j - 1 : 0];
                                    pt_next[j]   = pt_reg[(j > 0) ? j - 1 : 0];
                                end
                            end
                        end
                        if (filled_reg < FILL_W'(K_MAX)) begin
                            filled_next = filled_reg + 1'b1;
                        end
                    end
                    if (head_item.last) begin
                        n_take = int'(neighbors_wanted);
                        if (n_take > K_MAX) begin
                            n_take = K_MAX;
                        end
                        if (n_take > int'(filled_next)) begin
                            n_take = int'(filled_next);
                        end
                        if (n_take == 0) begin
                            filled_next = '0;
                        end else begin
                            state_next   = ST_EMIT;
                            remain_next  = FILL_W'(n_take);
                            run_ovf_next = head_item.ovf;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next.idx   = pt_reg[0];
                    out_next.last  = (remain_reg == FILL_W'(1));
                    out_next.ovf   = run_ovf_reg;
                    // the list drains toward cell zero
                    for (int j = 0; j < K_MAX - 1; j++) begin
                        dist_next[j] = dist_reg[j+1];
                        pt_next[j]   = pt_reg[j+1];
                    end
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == FILL_W'(1)) begin
                        state_next  = ST_INSERT;
                        filled_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_INSERT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INSERT;
            filled_reg    <= '0;
            remain_reg    <= '0;
            run_ovf_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            remain_reg    <= remain_next;
            run_ovf_reg   <= run_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        for (int j = 0; j < K_MAX; j++) begin
            dist_reg[j] <= dist_next[j];
            pt_reg[j]   <= pt_next[j];
        end
    end

endmodule

// ===== test/k_nearest_neighbor_select_tb.sv =====
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select_tb
// Streams training points into the nearest-neighbor selector and checks every
// reported index against a predicted sorted list of the nearest points. The
// run covers register extremes, distance ties, a long result-side stall that
// backs up the input, and random runs with bursty input and a stalling
// result side.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_select_tb;
    import knn_pkg::*;

    localparam int K_MAX        = K_MAX_DEF;
    localparam int MAX_POINTS   = MAX_POINTS_DEF;
    localparam int POINT_W      = DIM * COORD_W;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 340;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd5;
    localparam logic [COORD_W-1:0]    COORD_MIN = 24'h800000;
    localparam logic [COORD_W-1:0]    COORD_MAX = 24'h7fffff;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [POINT_W-1:0]    s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predicted state of the selector
    logic signed [COORD_W-1:0] query [DIM];
    logic [DIMS_W-1:0]         dims_sel;
    logic [WANT_W-1:0]         wanted;
    logic [DIST_W-1:0]         nearest_dist [K_MAX];
    logic [IDX_W-1:0]          nearest_idx [K_MAX];
    int                        kept;
    int                        arrivals;
    bit                        dropped_seen;
    knn_result_t               pending_neighbors [$];
    knn_result_t               next_neighbor;

    logic [POINT_W-1:0] prev_point = '0;
    int       burst_left     = 0;
    bit       tx_steady      = 1'b0;
    bit       hold_request   = 1'b0;
    int       hold_left      = 0;
    rx_mode_t rx_mode        = RX_OPEN;
    int       rx_left        = 0;
    int       cycle_count    = 0;
    int       mismatches     = 0;
    int       results_checked = 0;
    int       points_sent    = 0;
    int       runs_ended     = 0;
    int       cfg_writes     = 0;
    int       input_stalls   = 0;

    k_nearest_neighbor_select uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [POINT_W-1:0] pack_point(input logic [COORD_W-1:0] c0,
                                                      input logic [COORD_W-1:0] c1,
                                                      input logic [COORD_W-1:0] c2);
        return {c2, c1, c0};
    endfunction

    function automatic logic [DIST_W-1:0] squared_range(input logic [POINT_W-1:0] point);
        logic [DIST_W-1:0] sum;
        longint            diff;
        int                used;
        sum  = '0;
        used = (dims_sel == 0) ? 1 : int'(dims_sel);
        if (used > DIM) used = DIM;
        for (int d = 0; d < used; d++) begin
            diff = longint'($signed(point[d*COORD_W +: COORD_W])) - longint'(query[d]);
            if (diff < 0) diff = -diff;
            sum += DIST_W'(diff * diff);
        end
        return sum;
    endfunction

    // insert into the sorted list; on the last point queue the nearest indices
    function automatic void predict_point(input logic [POINT_W-1:0] point,
                                          input logic last);
        logic [DIST_W-1:0] range_sq;
        int                pos;
        int                j;
        int                n;
        knn_result_t       r;
        if (arrivals >= MAX_POINTS) begin
            dropped_seen = 1'b1;
        end else begin
            range_sq = squared_range(point);
            pos = 0;
            while (pos < kept && nearest_dist[pos] <= range_sq) pos++;
            if (pos < K_MAX) begin
                j = (kept < K_MAX) ? kept : K_MAX - 1;
                while (j > pos) begin
                    nearest_dist[j] = nearest_dist[j-1];
                    nearest_idx[j]  = nearest_idx[j-1];
                    j--;
                end
                nearest_dist[pos] = range_sq;
                nearest_idx[pos]  = IDX_W'(arrivals);
                if (kept < K_MAX) kept++;
            end
            arrivals++;
        end
        if (last) begin
            n = (int'(wanted) > K_MAX) ? K_MAX : int'(wanted);
            if (n > kept) n = kept;
            for (int k = 0; k < n; k++) begin
                r.idx  = nearest_idx[k];
                r.last = (k == n - 1);
                r.ovf  = dropped_seen;
                pending_neighbors.insert(pending_neighbors.size(), r);
            end
            kept         = 0;
            arrivals     = 0;
            dropped_seen = 1'b0;
            runs_ended++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_QUERY_0: query[0] = value;
            REG_QUERY_1: query[1] = value;
            REG_QUERY_2: query[2] = value;
            REG_DIMS:    dims_sel = value[DIMS_W-1:0];
            REG_WANTED:  wanted   = value[WANT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [COORD_W-1:0] q0, input logic [COORD_W-1:0] q1,
                              input logic [COORD_W-1:0] q2, input int dims, input int want);
        write_reg(REG_QUERY_0, q0);
        write_reg(REG_QUERY_1, q1);
        write_reg(REG_QUERY_2, q2);
        write_reg(REG_DIMS, CFG_DATA_W'(dims));
        write_reg(REG_WANTED, CFG_DATA_W'(want));
    endtask

    task automatic send_point(input logic [POINT_W-1:0] point, input logic last);
        int gap;
        gap = 0;
        if (!tx_steady) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= point;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_point(point, last);
        points_sent++;
    endtask

    // drop valid, wait for every predicted word, then let the pipeline empty
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int d);
        case ($urandom_range(0, 7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return query[d] + COORD_W'($urandom_range(0, 64)) - COORD_W'(32);
            4:       return prev_point[d*COORD_W +: COORD_W];
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [POINT_W-1:0] pick_point();
        logic [POINT_W-1:0] p;
        if ($urandom_range(0, 7) == 0) return prev_point;   // whole-point tie
        for (int d = 0; d < DIM; d++) p[d*COORD_W +: COORD_W] = pick_coord(d);
        prev_point = p;
        return p;
    endfunction

    task automatic send_random_run(input int len);
        for (int i = 0; i < len; i++) send_point(pick_point(), i == len - 1);
    endtask

    function automatic logic [COORD_W-1:0] pick_query();
        case ($urandom_range(0, 4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_wanted();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2, 3:    return K_MAX;
            4:       return 31;
            default: return $urandom_range(1, 31);
        endcase
    endfunction

    // result side: changing stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= ((rx_left % 5) < 3);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) input_stalls++;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_neighbors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected neighbor word: idx %0d last %0b dropped %0b",
                             m_tdata, m_tlast, m_tuser[0]);
            end else begin
                next_neighbor = pending_neighbors.pop_front();
                if (m_tdata !== next_neighbor.idx || m_tlast !== next_neighbor.last ||
                    m_tuser[0] !== next_neighbor.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("neighbor word mismatch: expected idx %0d last %0b dropped %0b, got idx %0d last %0b dropped %0b",
                                 next_neighbor.idx, next_neighbor.last, next_neighbor.ovf,
                                 m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    // defaults: dims 2, m 16, query at the origin
    task automatic test_reset_defaults();
        send_point(pack_point(COORD_MAX, COORD_MAX, '0), 1'b0);
        send_point(pack_point(COORD_MIN, COORD_MIN, COORD_MAX), 1'b0);
        send_point(pack_point('0, '0, COORD_MIN), 1'b0);
        send_point(pack_point(24'd1, 24'hffffff, COORD_MAX), 1'b0);
        send_point(pack_point(COORD_MIN, '0, '0), 1'b1);
        finish_phase();
    endtask

    // largest distances, ties at the top, m above the list size
    task automatic test_extreme_distance();
        set_config(COORD_MIN, COORD_MIN, COORD_MIN, 3, 31);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        send_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        send_point(pack_point(COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
        send_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
        send_point(pack_point(COORD_MIN, COORD_MAX, COORD_MIN), 1'b0);
        send_point(pack_point(COORD_MAX, COORD_MIN, COORD_MAX), 1'b1);
        finish_phase();
    endtask

    // dims 0 falls back to one coordinate
    task automatic test_dims_zero();
        set_config(COORD_MAX, '0, '0, 0, K_MAX);
        send_point(pack_point(COORD_MAX, COORD_MIN, COORD_MIN), 1'b0);
        send_point(pack_point(COORD_MAX - 24'd1, '0, '0), 1'b0);
        send_point(pack_point(COORD_MIN, '0, '0), 1'b0);
        send_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
        finish_phase();
    endtask

    // m of one, including a run of a single point
    task automatic test_one_neighbor();
        set_config(24'h001000, 24'hfff000, '0, 2, 1);
        send_point(pack_point(COORD_MIN, COORD_MAX, '0), 1'b1);
        send_point(pack_point(COORD_MAX, COORD_MAX, '0), 1'b0);
        send_point(pack_point(24'h001001, 24'hfff000, COORD_MAX), 1'b0);
        send_point(pack_point(24'h000fff, 24'hfff000, COORD_MIN), 1'b1);
        finish_phase();
    endtask

    // m of zero: the run ends with no words at all
    task automatic test_wanted_zero();
        write_reg(REG_WANTED, '0);
        send_point(pick_point(), 1'b0);
        send_point(pick_point(), 1'b0);
        send_point(pick_point(), 1'b1);
        finish_phase();
    endtask

    // long result-side hold-off while input keeps coming
    task automatic test_backpressure();
        set_config(pick_query(), pick_query(), pick_query(), 3, K_MAX);
        send_random_run(20);
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        send_random_run(30);
        tx_steady    = 1'b0;
        finish_phase();
    endtask

    task automatic test_random_runs();
        int start;
        int runs;
        int len;
        start = points_sent;
        while (points_sent - start < RANDOM_ITEMS) begin
            set_config(pick_query(), pick_query(), pick_query(), $urandom_range(0, 3),
                       pick_wanted());
            tx_steady = ($urandom_range(0, 3) == 0);
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 20);
                send_random_run(len);
            end
            finish_phase();
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        query[0]     = '0;
        query[1]     = '0;
        query[2]     = '0;
        dims_sel     = 2'd2;
        wanted       = WANT_W'(K_MAX);
        kept         = 0;
        arrivals     = 0;
        dropped_seen = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extreme_distance();
        test_dims_zero();
        test_one_neighbor();
        test_wanted_zero();
        test_backpressure();
        test_random_runs();

        if (pending_neighbors.size() != 0) mismatches++;
        $display("sent %0d points in %0d runs, checked %0d neighbor words, %0d register writes",
                 points_sent, runs_ended, results_checked, cfg_writes);
        $display("input held back for %0d cycles by result-side stalls, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
